// ===== rtl/mtcd_pkg.sv =====
package mtcd_pkg;

    // Field widths fixed by the interface definition.
    localparam int CAPTURE_W   = 32;
    localparam int SPEED_W     = 16;
    localparam int ANGLE_OUT_W = 16;

    // Configuration register widths.
    localparam int SPEED_CONST_W = 32;
    localparam int MIN_PERIOD_W  = 16;
    localparam int SPEED_LIMIT_W = 16;
    localparam int DEG_W         = 8;
    localparam int SYNC_LOSS_W   = 10;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CONSTANT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEGREES_PER_TOOTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LOSS_ANGLE   = 3'd4;

    // Register values after reset.
    localparam logic [SPEED_CONST_W-1:0] RST_SPEED_CONSTANT = 32'd221666666;
    localparam logic [MIN_PERIOD_W-1:0]  RST_MIN_PERIOD     = 16'd50;
    localparam logic [SPEED_LIMIT_W-1:0] RST_SPEED_LIMIT    = 16'd15000;
    localparam logic [DEG_W-1:0]         RST_DEGREES        = 8'd10;
    localparam logic [SYNC_LOSS_W-1:0]   RST_SYNC_LOSS      = 10'd360;

    // Default parameter values of the top level.
    localparam int COUNTER_BITS_DEF = 32;
    localparam int ANGLE_BITS_DEF   = 16;

endpackage

// ===== rtl/mtcd_in_if.sv =====
interface mtcd_in_if;
    logic                           valid;
    logic                           ready;
    logic [mtcd_pkg::CAPTURE_W-1:0] capture_count;

    modport source (output valid, output capture_count, input ready);
    modport sink (input valid, input capture_count, output ready);
endinterface

// ===== rtl/mtcd_out_if.sv =====
interface mtcd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [mtcd_pkg::SPEED_W-1:0]            engine_speed;
    logic                                    speed_updated;
    logic signed [mtcd_pkg::ANGLE_OUT_W-1:0] crank_angle;
    logic                                    in_sync;
    logic                                    gap_seen;

    modport source (output valid, output engine_speed, output speed_updated,
                    output crank_angle, output in_sync, output gap_seen, input ready);
    modport sink (input valid, input engine_speed, input speed_updated,
                  input crank_angle, input in_sync, input gap_seen, output ready);
endinterface

// ===== rtl/missing_tooth_crank_decoder.sv =====
// Missing-tooth crank decoder. Each input transaction carries one raw capture of a
// free-running down-counter taken at a crank tooth edge; each one produces exactly
// one output transaction with the held engine speed, a flag telling whether the
// speed was refreshed by this tooth, the crank angle since the last gap, the sync
// flag and a flag marking this tooth as the missing-tooth gap. The speed comes from
// a restoring divider that retires one quotient bit per cycle, so a tooth goes
// through an accept step, 32 divide steps and a final step that updates the
// decoder state and loads the output. The input is not ready while the divider
// runs. A finished result is held in the output register until it is taken, and
// the next capture is accepted while it waits; the following result then waits
// for that register to drain. Configuration writes are registered and are meant
// to be issued only while the decoder is idle. No clearing pass is needed after
// reset.
module missing_tooth_crank_decoder #(
    parameter int COUNTER_BITS = mtcd_pkg::COUNTER_BITS_DEF,
    parameter int ANGLE_BITS   = mtcd_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtcd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mtcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mtcd_in_if.sink                             i_cap,
    mtcd_out_if.source                          o_res
);

    // The dividend is the speed constant; one quotient bit comes out per step.
    localparam int DIV_W = mtcd_pkg::SPEED_CONST_W;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int GAP_W = COUNTER_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Configuration registers.
    logic [mtcd_pkg::SPEED_CONST_W-1:0] r_speed_constant;
    logic [mtcd_pkg::MIN_PERIOD_W-1:0]  r_min_period;
    logic [mtcd_pkg::SPEED_LIMIT_W-1:0] r_speed_limit;
    logic [mtcd_pkg::DEG_W-1:0]         r_degrees;
    logic [mtcd_pkg::SYNC_LOSS_W-1:0]   r_sync_loss;

    // Sequencer and divider.
    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [COUNTER_BITS-1:0] r_period;
    logic [COUNTER_BITS-1:0] r_rem;
    logic [DIV_W-1:0]        r_quo;

    // Decoder state.
    logic [COUNTER_BITS-1:0]     r_prev_period;
    logic [ANGLE_BITS-1:0]       r_angle;
    logic                        r_sync;
    logic [mtcd_pkg::SPEED_W-1:0] r_held_speed;

    // Output register: the engine speed, angle and sync flag are read straight from
    // the decoder state, which only moves when a new result is loaded.
    logic r_out_valid;
    logic r_out_updated;
    logic r_out_gap;

    logic                    w_accept;
    logic                    w_load;
    logic [COUNTER_BITS:0]   w_trial;
    logic [COUNTER_BITS:0]   w_diff;
    logic                    w_ge;
    logic                    w_speed_ok;
    logic [GAP_W-1:0]        w_twice;
    logic [GAP_W-1:0]        w_thrice;
    logic                    w_gap;
    logic [ANGLE_BITS-1:0]   w_angle_sum;
    logic signed [ANGLE_BITS:0] w_angle_ext;
    logic signed [ANGLE_BITS:0] w_loss_ext;
    logic signed [ANGLE_BITS-1:0] w_angle_s;

    logic [CNT_W-1:0]        n_cnt;
    logic [COUNTER_BITS-1:0] n_rem;
    logic [DIV_W-1:0]        n_quo;
    t_state                  n_state;

    assign w_accept = i_cap.valid && i_cap.ready;
    assign w_load   = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    // One restoring divide step: shift in the next dividend bit and subtract the
    // period when it fits.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_period};
    assign w_ge    = (w_trial >= {1'b0, r_period});

    always_comb begin
        n_rem = w_ge ? w_diff[COUNTER_BITS-1:0] : w_trial[COUNTER_BITS-1:0];
        n_quo = {r_quo[DIV_W-2:0], w_ge};
        n_cnt = r_cnt + CNT_W'(1);
    end

    // A speed is stored only for a long enough period and when it is below the limit.
    assign w_speed_ok = (r_period > COUNTER_BITS'(r_min_period)) &&
                        (r_quo < DIV_W'(r_speed_limit));

    // Gap test: twice the period against three times the previous period, exact.
    assign w_twice  = {1'b0, r_period, 1'b0};
    assign w_thrice = GAP_W'(r_prev_period) + {1'b0, r_prev_period, 1'b0};
    assign w_gap    = (r_prev_period != '0) && (w_twice > w_thrice);

    // Angle step wraps in ANGLE_BITS; sync drops once the signed angle reaches the
    // loss limit.
    assign w_angle_sum = r_angle + ANGLE_BITS'(r_degrees);
    assign w_angle_ext = $signed({w_angle_sum[ANGLE_BITS-1], w_angle_sum});
    assign w_loss_ext  = $signed({1'b0, ANGLE_BITS'(r_sync_loss)});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_constant <= mtcd_pkg::RST_SPEED_CONSTANT;
            r_min_period     <= mtcd_pkg::RST_MIN_PERIOD;
            r_speed_limit    <= mtcd_pkg::RST_SPEED_LIMIT;
            r_degrees        <= mtcd_pkg::RST_DEGREES;
            r_sync_loss      <= mtcd_pkg::RST_SYNC_LOSS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtcd_pkg::REG_SPEED_CONSTANT: begin
                    r_speed_constant <= i_cfg_data[mtcd_pkg::SPEED_CONST_W-1:0];
                end
                mtcd_pkg::REG_MIN_PERIOD: begin
                    r_min_period <= i_cfg_data[mtcd_pkg::MIN_PERIOD_W-1:0];
                end
                mtcd_pkg::REG_SPEED_LIMIT: begin
                    r_speed_limit <= i_cfg_data[mtcd_pkg::SPEED_LIMIT_W-1:0];
                end
                mtcd_pkg::REG_DEGREES_PER_TOOTH: begin
                    r_degrees <= i_cfg_data[mtcd_pkg::DEG_W-1:0];
                end
                mtcd_pkg::REG_SYNC_LOSS_ANGLE: begin
                    r_sync_loss <= i_cfg_data[mtcd_pkg::SYNC_LOSS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer, decoder state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev_period <= '0;
            r_angle       <= '0;
            r_sync        <= 1'b0;
            r_held_speed  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                if (w_speed_ok) begin
                    r_held_speed <= r_quo[mtcd_pkg::SPEED_W-1:0];
                end
                if (w_gap) begin
                    r_angle <= '0;
                    r_sync  <= 1'b1;
                end else begin
                    r_angle <= w_angle_sum;
                    if (w_angle_ext >= w_loss_ext) begin
                        r_sync <= 1'b0;
                    end
                end
                r_prev_period <= r_period;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider datapath and result flags; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // The period is the counter's all-ones value minus the capture.
            r_period <= ~i_cap.capture_count[COUNTER_BITS-1:0];
            r_rem    <= '0;
            r_quo    <= r_speed_constant;
            r_cnt    <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= n_cnt;
        end
        if (w_load) begin
            r_out_updated <= w_speed_ok;
            r_out_gap     <= w_gap;
        end
    end

    assign w_angle_s = $signed(r_angle);

    assign i_cap.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.engine_speed  = r_held_speed;
    assign o_res.speed_updated = r_out_updated;
    assign o_res.crank_angle   = mtcd_pkg::ANGLE_OUT_W'(w_angle_s);
    assign o_res.in_sync       = r_sync;
    assign o_res.gap_seen      = r_out_gap;

    // An accepted capture always starts the divider.
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DIV)
        else $error("accepted capture did not start the divider");

    // The held speed only moves when a result is loaded.
    a_speed_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_held_speed) |-> $past(w_load))
        else $error("held speed changed outside a result load");

    // A refreshed speed is always below the configured limit.
    a_speed_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.speed_updated) |-> (o_res.engine_speed < r_speed_limit))
        else $error("stored speed not below limit");

    // A gap tooth reports a zero angle and sync.
    a_gap_resets_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.gap_seen) |-> (o_res.crank_angle == '0 && o_res.in_sync))
        else $error("gap without zero angle and sync");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // The run is ended by force if it ever gets this far.
    localparam int CYCLE_LIMIT = 500000;
    // Cycles allowed for the decoder to settle once nothing is pending.
    localparam int SETTLE_CYCLES = 40;
    // An index past the last register; writes to it must change nothing.
    localparam logic [mtcd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    // One decoded tooth as the output channel presents it.
    typedef struct packed {
        logic [mtcd_pkg::SPEED_W-1:0]            speed;
        logic                                    updated;
        logic signed [mtcd_pkg::ANGLE_OUT_W-1:0] angle;
        logic                                    sync;
        logic                                    gap;
    } t_tooth_reading;

    // A row of the directed table. Rows with fixed set carry an expectation
    // typed in by hand; all others are checked against the predictor.
    typedef struct packed {
        logic [mtcd_pkg::CAPTURE_W-1:0] capture;
        logic                           fixed;
        t_tooth_reading                 reading;
    } t_directed_row;

    // The first six rows start from reset values and walk through the short
    // period, the speed just below and just at the limit, and the first gap.
    // The rest probe the exact 1.5x ratio, toggling patterns and the extreme
    // captures, and are left to the predictor.
    localparam t_directed_row TOOTH_TABLE [16] = '{
        '{32'hFFFF_FFFF, 1'b1, '{16'd0,     1'b0, 16'sd10, 1'b0, 1'b0}},
        '{32'h0000_0000, 1'b1, '{16'd0,     1'b1, 16'sd20, 1'b0, 1'b0}},
        '{32'hFFFF_FFCD, 1'b1, '{16'd0,     1'b0, 16'sd30, 1'b0, 1'b0}},
        '{32'hFFFF_FFCC, 1'b1, '{16'd0,     1'b0, 16'sd40, 1'b0, 1'b0}},
        '{32'hFFFF_C645, 1'b1, '{16'd14999, 1'b1, 16'sd0,  1'b1, 1'b1}},
        '{32'hFFFF_C646, 1'b1, '{16'd14999, 1'b0, 16'sd10, 1'b1, 1'b0}},
        '{32'hFFFF_FC17, 1'b0, '0},
        '{32'hFFFF_FA23, 1'b0, '0},
        '{32'hFFFF_FC17, 1'b0, '0},
        '{32'hFFFF_FA22, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0},
        '{32'hFFFF_FFFE, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [mtcd_pkg::CFG_INDEX_W-1:0]     i_cfg_index;
    logic [mtcd_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    mtcd_in_if  cap_if ();
    mtcd_out_if res_if ();

    missing_tooth_crank_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cap       (cap_if),
        .o_res       (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor: register copies start at their reset values, and the
    // tooth history starts cleared, exactly as the block comes out of reset.
    logic [mtcd_pkg::SPEED_CONST_W-1:0] set_speed_const = mtcd_pkg::RST_SPEED_CONSTANT;
    logic [mtcd_pkg::MIN_PERIOD_W-1:0]  set_min_period  = mtcd_pkg::RST_MIN_PERIOD;
    logic [mtcd_pkg::SPEED_LIMIT_W-1:0] set_speed_limit = mtcd_pkg::RST_SPEED_LIMIT;
    logic [mtcd_pkg::DEG_W-1:0]         set_degrees     = mtcd_pkg::RST_DEGREES;
    logic [mtcd_pkg::SYNC_LOSS_W-1:0]   set_sync_loss   = mtcd_pkg::RST_SYNC_LOSS;

    logic [mtcd_pkg::CAPTURE_W-1:0]   last_period = '0;
    logic [mtcd_pkg::ANGLE_OUT_W-1:0] angle_now   = '0;
    logic                             locked      = 1'b0;
    logic [mtcd_pkg::SPEED_W-1:0]     speed_hold  = '0;

    t_tooth_reading expected_readings [$];
    t_tooth_reading want;

    // Stimulus knobs: when set, that side of the handshake idles at random.
    bit idle_in  = 1'b1;
    bit idle_out = 1'b1;

    int cycle_count     = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int teeth_accepted  = 0;
    int setups_loaded   = 0;
    int gaps_predicted  = 0;
    int speed_refreshes = 0;
    int sync_drops      = 0;
    int angle_wraps     = 0;

    // Runs one tooth through the predictor and returns what the block must report.
    function automatic t_tooth_reading decode_tooth(
        input logic [mtcd_pkg::CAPTURE_W-1:0] capture
    );
        logic [mtcd_pkg::CAPTURE_W-1:0]   period;
        logic [mtcd_pkg::CAPTURE_W-1:0]   quotient;
        logic [mtcd_pkg::CAPTURE_W+2:0]   twice_now;
        logic [mtcd_pkg::CAPTURE_W+2:0]   thrice_last;
        logic [mtcd_pkg::ANGLE_OUT_W-1:0] old_angle;
        t_tooth_reading                   r;
        // The counter runs down from all ones, so the period is the complement.
        period = ~capture;
        r.updated = 1'b0;
        if (period > {16'd0, set_min_period}) begin
            quotient = set_speed_const / period;
            if (quotient < {16'd0, set_speed_limit}) begin
                speed_hold = quotient[mtcd_pkg::SPEED_W-1:0];
                r.updated = 1'b1;
                speed_refreshes++;
            end
        end
        // The 1.5x ratio test, kept exact by comparing 2*period with 3*previous.
        twice_now   = {2'b00, period, 1'b0};
        thrice_last = {3'b000, last_period} * 35'd3;
        r.gap = (last_period != '0) && (twice_now > thrice_last);
        if (r.gap) begin
            angle_now = '0;
            locked = 1'b1;
            gaps_predicted++;
        end else begin
            old_angle = angle_now;
            angle_now = angle_now + {8'd0, set_degrees};
            if (!old_angle[mtcd_pkg::ANGLE_OUT_W-1] && angle_now[mtcd_pkg::ANGLE_OUT_W-1]) begin
                angle_wraps++;
            end
            // The sync test sees the wrapped, signed angle.
            if ($signed(angle_now) >= $signed({6'd0, set_sync_loss})) begin
                if (locked) begin
                    sync_drops++;
                end
                locked = 1'b0;
            end
        end
        last_period = period;
        r.speed = speed_hold;
        r.angle = angle_now;
        r.sync  = locked;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at result %0d: %s", results_checked, what);
    endtask

    // Offers one capture and waits until the decoder takes it. Called right
    // after a rising edge; the valid line stays high into the next call so it
    // never gets two updates in one time step.
    task automatic send_tooth(input logic [mtcd_pkg::CAPTURE_W-1:0] capture,
                              input logic fixed,
                              input t_tooth_reading fixed_reading);
        t_tooth_reading predicted;
        if (idle_in && $urandom_range(0, 99) < 12) begin
            cap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        cap_if.valid         <= 1'b1;
        cap_if.capture_count <= capture;
        do @(posedge i_clk); while (cap_if.ready !== 1'b1);
        predicted = decode_tooth(capture);
        expected_readings.push_back(fixed ? fixed_reading : predicted);
        teeth_accepted++;
    endtask

    task automatic send_period(input logic [mtcd_pkg::CAPTURE_W-1:0] period);
        send_tooth(~period, 1'b0, '0);
    endtask

    // Stops the sender and waits until every pending transaction has come out.
    task automatic drain_results();
        cap_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    // Writes one register and mirrors it into the predictor. The enable is left
    // high so that back-to-back writes need only one update per step.
    task automatic write_register(input logic [mtcd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [mtcd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            mtcd_pkg::REG_SPEED_CONSTANT:
                set_speed_const = data[mtcd_pkg::SPEED_CONST_W-1:0];
            mtcd_pkg::REG_MIN_PERIOD:
                set_min_period = data[mtcd_pkg::MIN_PERIOD_W-1:0];
            mtcd_pkg::REG_SPEED_LIMIT:
                set_speed_limit = data[mtcd_pkg::SPEED_LIMIT_W-1:0];
            mtcd_pkg::REG_DEGREES_PER_TOOTH:
                set_degrees = data[mtcd_pkg::DEG_W-1:0];
            mtcd_pkg::REG_SYNC_LOSS_ANGLE:
                set_sync_loss = data[mtcd_pkg::SYNC_LOSS_W-1:0];
            default: ;
        endcase
    endtask

    // Loads a full register set once the decoder has gone idle. Bits above
    // each narrower register's width carry junk, which the block must ignore,
    // and a stray write to an unmapped index goes first.
    task automatic program_setup(input logic [mtcd_pkg::SPEED_CONST_W-1:0] speed_const,
                                 input logic [mtcd_pkg::MIN_PERIOD_W-1:0] min_period,
                                 input logic [mtcd_pkg::SPEED_LIMIT_W-1:0] speed_limit,
                                 input logic [mtcd_pkg::DEG_W-1:0] degrees,
                                 input logic [mtcd_pkg::SYNC_LOSS_W-1:0] sync_loss);
        drain_results();
        write_register(REG_UNMAPPED, $urandom());
        write_register(mtcd_pkg::REG_SPEED_CONSTANT, speed_const);
        write_register(mtcd_pkg::REG_MIN_PERIOD, {16'($urandom()), min_period});
        write_register(mtcd_pkg::REG_SPEED_LIMIT, {16'($urandom()), speed_limit});
        write_register(mtcd_pkg::REG_DEGREES_PER_TOOTH, {24'($urandom()), degrees});
        write_register(mtcd_pkg::REG_SYNC_LOSS_ANGLE, {22'($urandom()), sync_loss});
        i_cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    // Random crank traffic. Most of it is whole revolutions of a 36-1 wheel at
    // a random speed with a little jitter, ended by a long gap tooth; some of
    // it is cut-short revolutions, and the rest is single noisy captures.
    task automatic run_traffic(input int teeth);
        int                             done_teeth;
        int                             kind;
        int                             run_len;
        logic [mtcd_pkg::CAPTURE_W-1:0] base;
        logic [mtcd_pkg::CAPTURE_W-1:0] period;
        logic [mtcd_pkg::CAPTURE_W+1:0] ratio_edge;
        done_teeth = 0;
        while (done_teeth < teeth) begin
            kind = $urandom_range(0, 99);
            // Spread the speed over many decades of tooth period.
            base = $urandom_range(1, 32'd1 << $urandom_range(1, 30));
            if (kind < 90) begin
                run_len = (kind < 75) ? 35 : $urandom_range(1, 12);
                repeat (run_len) begin
                    send_period(base - (base >> 5) + $urandom_range(0, base >> 4));
                    done_teeth++;
                end
                if (kind < 75 || $urandom_range(0, 1) == 1) begin
                    if ($urandom_range(0, 4) == 0) begin
                        // Land on, just below or just past the 1.5x boundary.
                        ratio_edge = {2'b00, last_period} * 34'd3;
                        period = ratio_edge[mtcd_pkg::CAPTURE_W:1] + $urandom_range(0, 1);
                    end else begin
                        period = 2 * base + $urandom_range(0, base);
                    end
                    send_period(period);
                    done_teeth++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send_tooth($urandom(), 1'b0, '0);
                    1: send_period({16'd0, set_min_period} + $urandom_range(0, 1));
                    default: send_period($urandom_range(0, 3));
                endcase
                done_teeth++;
            end
        end
    endtask

    // Output side: the sink stalls at random while idle_out is set.
    always @(posedge i_clk) begin
        res_if.ready <= !idle_out || ($urandom_range(0, 99) >= 12);
    end

    // Result checker: every transaction on the output channel is compared
    // field by field with the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_checked++;
            if (expected_readings.size() == 0) begin
                report_mismatch("result arrived with nothing pending");
            end else begin
                want = expected_readings.pop_front();
                if (res_if.engine_speed !== want.speed)
                    report_mismatch($sformatf("engine_speed got %0d want %0d",
                                              res_if.engine_speed, want.speed));
                if (res_if.speed_updated !== want.updated)
                    report_mismatch($sformatf("speed_updated got %b want %b",
                                              res_if.speed_updated, want.updated));
                if (res_if.crank_angle !== want.angle)
                    report_mismatch($sformatf("crank_angle got %0d want %0d",
                                              res_if.crank_angle, want.angle));
                if (res_if.in_sync !== want.sync)
                    report_mismatch($sformatf("in_sync got %b want %b",
                                              res_if.in_sync, want.sync));
                if (res_if.gap_seen !== want.gap)
                    report_mismatch($sformatf("gap_seen got %b want %b",
                                              res_if.gap_seen, want.gap));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, expected_readings.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= '0;
        i_cfg_data           <= '0;
        cap_if.valid         <= 1'b0;
        cap_if.capture_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed teeth at the reset register values.
        foreach (TOOTH_TABLE[i]) begin
            send_tooth(TOOTH_TABLE[i].capture, TOOTH_TABLE[i].fixed,
                       TOOTH_TABLE[i].reading);
        end

        // Widest settings, run with both sides streaming and no idling at all.
        program_setup(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 8'd180, 10'd720);
        idle_in  = 1'b0;
        idle_out = 1'b0;
        run_traffic(120);

        // Narrowest settings: only a period above 65535 qualifies for a speed, which
        // is then zero, and sync drops on the first ordinary tooth.
        program_setup(32'd1, 16'hFFFF, 16'd1, 8'd1, 10'd1);
        idle_in  = 1'b1;
        idle_out = 1'b1;
        run_traffic(110);

        // Zero dividend and zero limit, the full-width step and a zero loss
        // angle, so no speed is ever stored and sync never survives a tooth.
        program_setup(32'd0, 16'd1, 16'd0, 8'd255, 10'd0);
        run_traffic(90);

        // One gap, then a long run of equal teeth with a big step so the
        // angle climbs past the top of its range and wraps negative.
        program_setup(mtcd_pkg::RST_SPEED_CONSTANT, mtcd_pkg::RST_MIN_PERIOD,
                      mtcd_pkg::RST_SPEED_LIMIT, 8'd180, 10'h3FF);
        send_period(32'd20000);
        send_period(32'd50000);
        repeat (190) send_period(32'd20000);

        repeat (3) begin
            program_setup($urandom(), 16'($urandom_range(0, 400)),
                          16'($urandom_range(1, 65535)), 8'($urandom_range(1, 180)),
                          10'($urandom_range(1, 720)));
            run_traffic(80);
        end

        // Back to the power-on values.
        program_setup(mtcd_pkg::RST_SPEED_CONSTANT, mtcd_pkg::RST_MIN_PERIOD,
                      mtcd_pkg::RST_SPEED_LIMIT, mtcd_pkg::RST_DEGREES,
                      mtcd_pkg::RST_SYNC_LOSS);
        run_traffic(80);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Decoded %0d teeth under %0d register setups: %0d gaps, %0d speed refreshes.",
                 teeth_accepted, setups_loaded + 1, gaps_predicted, speed_refreshes);
        $display("Sync was lost %0d times and the angle wrapped %0d times; %0d mismatches.",
                 sync_drops, angle_wraps, mismatches);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
